// ===== hw/rtl/combination_rank_unrank_core_assert.svh =====
// Assertion macros for the checker file of the combination rank/unrank core.
`ifndef COMBINATION_RANK_UNRANK_CORE_ASSERT_SVH
`define COMBINATION_RANK_UNRANK_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CRU_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CRU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cru_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the rank/unrank core.
package cru_pkg;

  localparam int MAX_SET    = 64;
  localparam int MAX_SUBSET = 6;

  localparam int SET_W   = 7;
  localparam int SUB_W   = 3;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;
  localparam int RANK_W  = 27;
  localparam int POS_W   = $clog2(MAX_SET);
  localparam int A_W     = $clog2(MAX_SET + 1);
  localparam int K_W     = $clog2(MAX_SUBSET + 1);
  localparam int IDX_W   = (MAX_SUBSET > 1) ? $clog2(MAX_SUBSET) : 1;
  localparam int C_W     = $clog2(MAX_SET + MAX_SUBSET + 2);
  localparam int T_W     = RANK_W + 1;
  localparam int SUM_W   = RANK_W + 3;
  localparam int ADDR_W  = A_W + K_W;
  localparam int TAB_DEPTH = (MAX_SET + 1) * (2 ** K_W);

  localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUBSET_SIZE = 1'd1;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_RANK,
    STATUS_POS,
    STATUS_CFG
  } status_t;

  typedef enum logic {
    CMD_UNRANK,
    CMD_RANK
  } command_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_FILL,
    OP_LOAD,
    OP_FAIL,
    OP_TOTAL,
    OP_SKIP,
    OP_PLACE,
    OP_ADD,
    OP_OUT
  } op_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_TOTAL,
    RD_UNRANK,
    RD_RANK
  } rd_sel_t;

  typedef enum logic [3:0] {
    ST_FILL,
    ST_IDLE,
    ST_CHECK,
    ST_TOTAL,
    ST_UN_LOOP,
    ST_UN_EVAL,
    ST_RK_LOOP,
    ST_RK_EVAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t     op;
    rd_sel_t rsel;
    status_t code;
  } ctl_cmd_t;

  typedef struct packed {
    logic     fill_last;
    logic     cfg_bad;
    command_t cmd;
    logic     rank_big;
    logic     pos_bad;
    logic     c_le_n;
    logic     take;
    logic     i_last;
    logic     out_free;
  } dp_status_t;

endpackage

// ===== hw/rtl/cru_datapath.sv =====
// Datapath: config registers, binomial table and its fill, rank/unrank registers, output beat.
module cru_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [cru_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cru_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               command,
  input  logic [cru_pkg::RANK_W-1:0]         rank_in,
  input  logic [cru_pkg::POS_W-1:0]          in_pos_0,
  input  logic [cru_pkg::POS_W-1:0]          in_pos_1,
  input  logic [cru_pkg::POS_W-1:0]          in_pos_2,
  input  logic [cru_pkg::POS_W-1:0]          in_pos_3,
  input  logic [cru_pkg::POS_W-1:0]          in_pos_4,
  input  logic [cru_pkg::POS_W-1:0]          in_pos_5,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [cru_pkg::RANK_W-1:0]         rank_out,
  output logic [cru_pkg::POS_W-1:0]          out_pos_0,
  output logic [cru_pkg::POS_W-1:0]          out_pos_1,
  output logic [cru_pkg::POS_W-1:0]          out_pos_2,
  output logic [cru_pkg::POS_W-1:0]          out_pos_3,
  output logic [cru_pkg::POS_W-1:0]          out_pos_4,
  output logic [cru_pkg::POS_W-1:0]          out_pos_5,
  output logic [1:0]                         status,
  input  cru_pkg::ctl_cmd_t                  cmd,
  output cru_pkg::dp_status_t                stat
);

  logic [cru_pkg::SET_W-1:0]   set_size;
  logic [cru_pkg::SUB_W-1:0]   subset_size;

  logic [cru_pkg::RANK_W-1:0]  binom_mem [0:cru_pkg::TAB_DEPTH-1];
  logic [cru_pkg::RANK_W-1:0]  rdata;
  logic [cru_pkg::ADDR_W-1:0]  rd_addr;

  logic [cru_pkg::A_W-1:0]     fill_a;
  logic [cru_pkg::K_W-1:0]     fill_k;
  logic [cru_pkg::RANK_W-1:0]  row [0:cru_pkg::MAX_SUBSET];
  logic [cru_pkg::RANK_W-1:0]  fill_val;

  cru_pkg::command_t           cmd_r;
  cru_pkg::status_t            status_r;
  logic [cru_pkg::RANK_W-1:0]  rank_r;
  logic [cru_pkg::RANK_W-1:0]  total;
  logic [cru_pkg::T_W-1:0]     t;
  logic [cru_pkg::C_W-1:0]     c;
  logic [cru_pkg::K_W-1:0]     i;
  logic [cru_pkg::SUM_W-1:0]   sum;
  logic [cru_pkg::POS_W-1:0]   in_pos [0:cru_pkg::MAX_SUBSET-1];
  logic [cru_pkg::POS_W-1:0]   pos    [0:cru_pkg::MAX_SUBSET-1];

  logic [cru_pkg::POS_W-1:0]   p_sel;
  logic [cru_pkg::A_W-1:0]     un_a;
  logic [cru_pkg::K_W-1:0]     un_k;
  logic [cru_pkg::A_W-1:0]     rk_a;
  logic [cru_pkg::K_W-1:0]     rk_k;
  logic [cru_pkg::SUM_W-1:0]   sum_p1;
  logic [cru_pkg::RANK_W-1:0]  rank_calc;
  logic                        pos_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_size    <= cru_pkg::SET_W'(8);
      subset_size <= cru_pkg::SUB_W'(2);
    end else if (cfg_write) begin
      unique case (cfg_index)
        cru_pkg::REG_SET_SIZE:    set_size    <= cfg_data[cru_pkg::SET_W-1:0];
        cru_pkg::REG_SUBSET_SIZE: subset_size <= cfg_data[cru_pkg::SUB_W-1:0];
      endcase
    end
  end

  assign fill_val = (fill_a == '0 || fill_k == '0) ? row[0] : row[0] + row[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_a <= '0;
      fill_k <= cru_pkg::K_W'(cru_pkg::MAX_SUBSET);
      for (int j = 0; j < cru_pkg::MAX_SUBSET; j++) begin
        row[j] <= '0;
      end
      row[cru_pkg::MAX_SUBSET] <= cru_pkg::RANK_W'(1);
    end else if (cmd.op == cru_pkg::OP_FILL) begin
      for (int j = 0; j < cru_pkg::MAX_SUBSET; j++) begin
        row[j] <= row[j+1];
      end
      row[cru_pkg::MAX_SUBSET] <= fill_val;
      if (fill_k == '0) begin
        fill_k <= cru_pkg::K_W'(cru_pkg::MAX_SUBSET);
        fill_a <= fill_a + cru_pkg::A_W'(1);
      end else begin
        fill_k <= fill_k - cru_pkg::K_W'(1);
      end
    end
  end

  assign p_sel = in_pos[i[cru_pkg::IDX_W-1:0]];
  assign un_a  = cru_pkg::A_W'(cru_pkg::C_W'(set_size) - c);
  assign un_k  = cru_pkg::K_W'(subset_size) - i - cru_pkg::K_W'(1);
  assign rk_a  = cru_pkg::A_W'(set_size) - cru_pkg::A_W'(p_sel) - cru_pkg::A_W'(1);
  assign rk_k  = cru_pkg::K_W'(subset_size) - i;

  always_comb begin
    unique case (cmd.rsel)
      cru_pkg::RD_UNRANK: rd_addr = {un_a, un_k};
      cru_pkg::RD_RANK:   rd_addr = {rk_a, rk_k};
      cru_pkg::RD_TOTAL:  rd_addr = {cru_pkg::A_W'(set_size), cru_pkg::K_W'(subset_size)};
      default:            rd_addr = {cru_pkg::A_W'(set_size), cru_pkg::K_W'(subset_size)};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == cru_pkg::OP_FILL) begin
      binom_mem[{fill_a, fill_k}] <= fill_val;
    end
    if (cmd.rsel != cru_pkg::RD_NONE) begin
      rdata <= binom_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      cru_pkg::OP_LOAD: begin
        cmd_r    <= cru_pkg::command_t'(command);
        status_r <= cru_pkg::STATUS_OK;
        rank_r   <= rank_in;
        t        <= cru_pkg::T_W'(rank_in) + cru_pkg::T_W'(1);
        c        <= cru_pkg::C_W'(1);
        i        <= '0;
        sum      <= '0;
        in_pos[0] <= in_pos_0;
        in_pos[1] <= in_pos_1;
        in_pos[2] <= in_pos_2;
        in_pos[3] <= in_pos_3;
        in_pos[4] <= in_pos_4;
        in_pos[5] <= in_pos_5;
        for (int j = 0; j < cru_pkg::MAX_SUBSET; j++) begin
          pos[j] <= '0;
        end
      end
      cru_pkg::OP_FAIL:  status_r <= cmd.code;
      cru_pkg::OP_TOTAL: total <= rdata;
      cru_pkg::OP_SKIP: begin
        t <= t - cru_pkg::T_W'(rdata);
        c <= c + cru_pkg::C_W'(1);
      end
      cru_pkg::OP_PLACE: begin
        pos[i[cru_pkg::IDX_W-1:0]] <= cru_pkg::POS_W'(c - cru_pkg::C_W'(1));
        c <= c + cru_pkg::C_W'(1);
        i <= i + cru_pkg::K_W'(1);
      end
      cru_pkg::OP_ADD: begin
        sum <= sum + cru_pkg::SUM_W'(rdata);
        i   <= i + cru_pkg::K_W'(1);
      end
      cru_pkg::OP_NONE, cru_pkg::OP_FILL, cru_pkg::OP_OUT: begin
      end
      default: begin
      end
    endcase
  end

  assign sum_p1    = sum + cru_pkg::SUM_W'(1);
  assign rank_calc = (sum_p1 > cru_pkg::SUM_W'(total)) ? '0
                   : cru_pkg::RANK_W'(cru_pkg::SUM_W'(total) - sum_p1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == cru_pkg::OP_OUT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == cru_pkg::OP_OUT) begin
      rank_out  <= (status_r == cru_pkg::STATUS_OK && cmd_r == cru_pkg::CMD_RANK)
                 ? rank_calc : '0;
      out_pos_0 <= pos[0];
      out_pos_1 <= pos[1];
      out_pos_2 <= pos[2];
      out_pos_3 <= pos[3];
      out_pos_4 <= pos[4];
      out_pos_5 <= pos[5];
      status    <= status_r;
    end
  end

  always_comb begin
    pos_bad = 1'b0;
    for (int j = 0; j < cru_pkg::MAX_SUBSET; j++) begin
      if (cru_pkg::SUB_W'(j) < subset_size
          && cru_pkg::SET_W'(in_pos[j]) >= set_size) begin
        pos_bad = 1'b1;
      end
    end
    for (int j = 1; j < cru_pkg::MAX_SUBSET; j++) begin
      if (cru_pkg::SUB_W'(j) < subset_size && in_pos[j] <= in_pos[j-1]) begin
        pos_bad = 1'b1;
      end
    end
  end

  always_comb begin
    stat.fill_last = (fill_a == cru_pkg::A_W'(cru_pkg::MAX_SET)) && (fill_k == '0);
    stat.cfg_bad   = (subset_size == '0)
                  || (subset_size > cru_pkg::SUB_W'(cru_pkg::MAX_SUBSET))
                  || (set_size == '0)
                  || (set_size > cru_pkg::SET_W'(cru_pkg::MAX_SET))
                  || (cru_pkg::SET_W'(subset_size) > set_size);
    stat.cmd       = cmd_r;
    stat.rank_big  = rank_r >= rdata;
    stat.pos_bad   = pos_bad;
    stat.c_le_n    = c <= cru_pkg::C_W'(set_size);
    stat.take      = t > cru_pkg::T_W'(rdata);
    stat.i_last    = i == (cru_pkg::K_W'(subset_size) - cru_pkg::K_W'(1));
    stat.out_free  = !out_valid || !out_stall;
  end

endmodule

// ===== hw/rtl/cru_controller.sv =====
// Controller state machine: table fill, input acceptance and rank/unrank sequencing.
module cru_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cru_pkg::dp_status_t  stat,
  output cru_pkg::ctl_cmd_t    cmd
);

  cru_pkg::state_t state;
  cru_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cru_pkg::ST_FILL;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = state != cru_pkg::ST_IDLE;

  always_comb begin
    state_next = state;
    cmd.op     = cru_pkg::OP_NONE;
    cmd.rsel   = cru_pkg::RD_NONE;
    cmd.code   = cru_pkg::STATUS_OK;
    unique case (state)
      cru_pkg::ST_FILL: begin
        cmd.op = cru_pkg::OP_FILL;
        if (stat.fill_last) begin
          state_next = cru_pkg::ST_IDLE;
        end
      end
      cru_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = cru_pkg::OP_LOAD;
          state_next = cru_pkg::ST_CHECK;
        end
      end
      cru_pkg::ST_CHECK: begin
        if (stat.cfg_bad) begin
          cmd.op     = cru_pkg::OP_FAIL;
          cmd.code   = cru_pkg::STATUS_CFG;
          state_next = cru_pkg::ST_DONE;
        end else begin
          cmd.rsel   = cru_pkg::RD_TOTAL;
          state_next = cru_pkg::ST_TOTAL;
        end
      end
      cru_pkg::ST_TOTAL: begin
        if (stat.cmd == cru_pkg::CMD_UNRANK) begin
          if (stat.rank_big) begin
            cmd.op     = cru_pkg::OP_FAIL;
            cmd.code   = cru_pkg::STATUS_RANK;
            state_next = cru_pkg::ST_DONE;
          end else begin
            state_next = cru_pkg::ST_UN_LOOP;
          end
        end else if (stat.pos_bad) begin
          cmd.op     = cru_pkg::OP_FAIL;
          cmd.code   = cru_pkg::STATUS_POS;
          state_next = cru_pkg::ST_DONE;
        end else begin
          cmd.op     = cru_pkg::OP_TOTAL;
          state_next = cru_pkg::ST_RK_LOOP;
        end
      end
      cru_pkg::ST_UN_LOOP: begin
        if (stat.c_le_n) begin
          cmd.rsel   = cru_pkg::RD_UNRANK;
          state_next = cru_pkg::ST_UN_EVAL;
        end else begin
          cmd.op     = cru_pkg::OP_PLACE;
          state_next = stat.i_last ? cru_pkg::ST_DONE : cru_pkg::ST_UN_LOOP;
        end
      end
      cru_pkg::ST_UN_EVAL: begin
        if (stat.take) begin
          cmd.op     = cru_pkg::OP_SKIP;
          state_next = cru_pkg::ST_UN_LOOP;
        end else begin
          cmd.op     = cru_pkg::OP_PLACE;
          state_next = stat.i_last ? cru_pkg::ST_DONE : cru_pkg::ST_UN_LOOP;
        end
      end
      cru_pkg::ST_RK_LOOP: begin
        cmd.rsel   = cru_pkg::RD_RANK;
        state_next = cru_pkg::ST_RK_EVAL;
      end
      cru_pkg::ST_RK_EVAL: begin
        cmd.op     = cru_pkg::OP_ADD;
        state_next = stat.i_last ? cru_pkg::ST_DONE : cru_pkg::ST_RK_LOOP;
      end
      cru_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd.op     = cru_pkg::OP_OUT;
          state_next = cru_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cru_pkg::ST_FILL;
      end
    endcase
  end

endmodule

// ===== hw/rtl/combination_rank_unrank_core.sv =====
// Combination rank/unrank core: converts between the lexicographic rank of an m-subset of
// {0..n-1} and its ascending positions, with n and m from the config registers. After reset
// the core builds its binomial table by Pascal's rule, one entry per cycle, for all 455 entries
// ((MAX_SET+1)*(MAX_SUBSET+1)), and holds in_stall high meanwhile; config writes are taken at
// any time. One item is worked at a time. Every binomial comes from the single read port of
// that table, one lookup then one compare or add per step. Unrank steps through candidate
// positions up to the last one placed; rank takes one step per subset element; a bad config
// goes straight to the output. The output register holds a finished beat while the next item
// is accepted.
module combination_rank_unrank_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [cru_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cru_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           command,
  input  logic [cru_pkg::RANK_W-1:0]     rank_in,
  input  logic [cru_pkg::POS_W-1:0]      in_pos_0,
  input  logic [cru_pkg::POS_W-1:0]      in_pos_1,
  input  logic [cru_pkg::POS_W-1:0]      in_pos_2,
  input  logic [cru_pkg::POS_W-1:0]      in_pos_3,
  input  logic [cru_pkg::POS_W-1:0]      in_pos_4,
  input  logic [cru_pkg::POS_W-1:0]      in_pos_5,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cru_pkg::RANK_W-1:0]     rank_out,
  output logic [cru_pkg::POS_W-1:0]      out_pos_0,
  output logic [cru_pkg::POS_W-1:0]      out_pos_1,
  output logic [cru_pkg::POS_W-1:0]      out_pos_2,
  output logic [cru_pkg::POS_W-1:0]      out_pos_3,
  output logic [cru_pkg::POS_W-1:0]      out_pos_4,
  output logic [cru_pkg::POS_W-1:0]      out_pos_5,
  output logic [1:0]                     status
);

  cru_pkg::ctl_cmd_t   cmd;
  cru_pkg::dp_status_t stat;

  cru_controller u_controller (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  cru_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .command   (command),
    .rank_in   (rank_in),
    .in_pos_0  (in_pos_0),
    .in_pos_1  (in_pos_1),
    .in_pos_2  (in_pos_2),
    .in_pos_3  (in_pos_3),
    .in_pos_4  (in_pos_4),
    .in_pos_5  (in_pos_5),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rank_out  (rank_out),
    .out_pos_0 (out_pos_0),
    .out_pos_1 (out_pos_1),
    .out_pos_2 (out_pos_2),
    .out_pos_3 (out_pos_3),
    .out_pos_4 (out_pos_4),
    .out_pos_5 (out_pos_5),
    .status    (status),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== hw/rtl/cru_checker.sv =====
// Port-level checker for the combination rank/unrank core and its bind.
`include "combination_rank_unrank_core_assert.svh"

module cru_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [cru_pkg::RANK_W-1:0]  rank_out,
  input logic [cru_pkg::POS_W-1:0]   out_pos_0,
  input logic [cru_pkg::POS_W-1:0]   out_pos_1,
  input logic [cru_pkg::POS_W-1:0]   out_pos_2,
  input logic [cru_pkg::POS_W-1:0]   out_pos_3,
  input logic [cru_pkg::POS_W-1:0]   out_pos_4,
  input logic [cru_pkg::POS_W-1:0]   out_pos_5,
  input logic [1:0]                  status
);

  `CRU_ASSERT_IMPLY(a_error_zero, out_valid && status != cru_pkg::STATUS_OK, rank_out == '0 && out_pos_0 == '0 && out_pos_1 == '0 && out_pos_2 == '0 && out_pos_3 == '0 && out_pos_4 == '0 && out_pos_5 == '0, "error beat carries nonzero data")
  `CRU_ASSERT_IMPLY(a_rank_no_pos, out_valid && rank_out != '0, status == cru_pkg::STATUS_OK && out_pos_0 == '0 && out_pos_1 == '0 && out_pos_2 == '0 && out_pos_3 == '0 && out_pos_4 == '0 && out_pos_5 == '0, "rank beat carries positions")
  `CRU_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "second item accepted while busy")
  `CRU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(rank_out) && $stable(status) && $stable(out_pos_0) && $stable(out_pos_5), "stalled output beat changed")

endmodule

bind combination_rank_unrank_core cru_checker u_checker (.*);

// ===== test/combination_rank_unrank_core_tb.sv =====
// Testbench for the combination rank/unrank core: directed and random beats checked against a predictor.
`timescale 1ns / 1ps

module combination_rank_unrank_core_tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEMS_PER_SETTING = 24;
  localparam int SETTINGS_PER_PHASE = 7;

  typedef struct packed {
    cru_pkg::command_t                                    cmd;
    logic [cru_pkg::RANK_W-1:0]                           rank;
    logic [cru_pkg::MAX_SUBSET-1:0][cru_pkg::POS_W-1:0]   pos;
  } request_t;

  typedef struct packed {
    logic [cru_pkg::RANK_W-1:0]                           rank;
    logic [cru_pkg::MAX_SUBSET-1:0][cru_pkg::POS_W-1:0]   pos;
    cru_pkg::status_t                                     status;
  } conversion_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [cru_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cru_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          command = 1'b0;
  logic [cru_pkg::RANK_W-1:0]    rank_in = '0;
  logic [cru_pkg::POS_W-1:0]     in_pos_0 = '0;
  logic [cru_pkg::POS_W-1:0]     in_pos_1 = '0;
  logic [cru_pkg::POS_W-1:0]     in_pos_2 = '0;
  logic [cru_pkg::POS_W-1:0]     in_pos_3 = '0;
  logic [cru_pkg::POS_W-1:0]     in_pos_4 = '0;
  logic [cru_pkg::POS_W-1:0]     in_pos_5 = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [cru_pkg::RANK_W-1:0]    rank_out;
  logic [cru_pkg::POS_W-1:0]     out_pos_0;
  logic [cru_pkg::POS_W-1:0]     out_pos_1;
  logic [cru_pkg::POS_W-1:0]     out_pos_2;
  logic [cru_pkg::POS_W-1:0]     out_pos_3;
  logic [cru_pkg::POS_W-1:0]     out_pos_4;
  logic [cru_pkg::POS_W-1:0]     out_pos_5;
  logic [1:0]                    status;

  logic [cru_pkg::SET_W-1:0]     set_n = 7'd8;
  logic [cru_pkg::SUB_W-1:0]     subset_m = 3'd2;
  conversion_t                   pending_conversions [$];
  int                            fail_count = 0;
  int                            cycle_count = 0;
  int                            tx_idle_pct = 10;
  int                            rx_stall_pct = 58;
  string                         field_name [8] = '{"rank_out", "out_pos_0", "out_pos_1",
                                                    "out_pos_2", "out_pos_3", "out_pos_4",
                                                    "out_pos_5", "status"};

  combination_rank_unrank_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .rank_in   (rank_in),
    .in_pos_0  (in_pos_0),
    .in_pos_1  (in_pos_1),
    .in_pos_2  (in_pos_2),
    .in_pos_3  (in_pos_3),
    .in_pos_4  (in_pos_4),
    .in_pos_5  (in_pos_5),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rank_out  (rank_out),
    .out_pos_0 (out_pos_0),
    .out_pos_1 (out_pos_1),
    .out_pos_2 (out_pos_2),
    .out_pos_3 (out_pos_3),
    .out_pos_4 (out_pos_4),
    .out_pos_5 (out_pos_5),
    .status    (status)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[combination_rank_unrank_core] ERROR");
      $finish;
    end
  end

  function automatic longint unsigned binomial(longint unsigned n, longint unsigned k);
    longint unsigned r;
    longint unsigned p;
    longint unsigned x;
    r = 1;
    p = n;
    if (k > n) return 0;
    for (x = 1; x <= k; x++) begin
      r = r * p / x;
      p--;
    end
    return r;
  endfunction

  function automatic conversion_t convert_item(request_t req);
    conversion_t     res;
    longint unsigned n;
    longint unsigned m;
    longint unsigned total;
    longint unsigned t;
    longint unsigned c;
    longint unsigned p;
    longint unsigned prev;
    longint unsigned sum;
    longint unsigned tmp;
    int              i;
    logic            bad;
    res = '0;
    n = set_n;
    m = subset_m;
    if (m == 0 || m > cru_pkg::MAX_SUBSET || n == 0 || n > cru_pkg::MAX_SET || m > n) begin
      res.status = cru_pkg::STATUS_CFG;
      return res;
    end
    total = binomial(n, m);
    if (req.cmd == cru_pkg::CMD_UNRANK) begin
      t = req.rank;
      if (t >= total) begin
        res.status = cru_pkg::STATUS_RANK;
      end else begin
        t = t + 1;
        c = 1;
        for (i = 0; i < m; i++) begin
          while (c <= n && t > binomial(n - c, m - i - 1)) begin
            t -= binomial(n - c, m - i - 1);
            c++;
          end
          tmp = c - 1;
          res.pos[i] = tmp[cru_pkg::POS_W-1:0];
          c++;
        end
      end
    end else begin
      bad = 1'b0;
      prev = 0;
      for (i = 0; i < m; i++) begin
        p = req.pos[i];
        if (p >= n || (i > 0 && p <= prev)) bad = 1'b1;
        prev = p;
      end
      if (bad) begin
        res.status = cru_pkg::STATUS_POS;
      end else begin
        sum = 0;
        for (i = 0; i < m; i++) begin
          p = req.pos[i];
          sum += binomial(n - p - 1, m - i);
        end
        if (sum + 1 <= total) begin
          tmp = total - sum - 1;
          res.rank = tmp[cru_pkg::RANK_W-1:0];
        end
      end
    end
    return res;
  endfunction

  function automatic logic [cru_pkg::POS_W-1:0] random_pos();
    logic [31:0] r;
    r = $urandom;
    return r[cru_pkg::POS_W-1:0];
  endfunction

  function automatic request_t random_request();
    request_t        req;
    logic [31:0]     r;
    longint unsigned total;
    longint unsigned tmp;
    int unsigned     n;
    int unsigned     m;
    int unsigned     need;
    int unsigned     roll;
    int unsigned     i;
    int unsigned     j;
    n = set_n;
    m = subset_m;
    r = $urandom;
    req.cmd = r[31] ? cru_pkg::CMD_RANK : cru_pkg::CMD_UNRANK;
    req.rank = r[cru_pkg::RANK_W-1:0];
    for (j = 0; j < cru_pkg::MAX_SUBSET; j++) req.pos[j] = random_pos();
    roll = $urandom_range(99);
    if (m == 0 || m > cru_pkg::MAX_SUBSET || n == 0 || n > cru_pkg::MAX_SET || m > n) return req;
    total = binomial(n, m);
    if (req.cmd == cru_pkg::CMD_UNRANK) begin
      if (roll < 80) tmp = longint'($urandom) % total;
      else if (roll < 88) tmp = total - 1;
      else if (roll < 94) tmp = total;
      else tmp = req.rank;
      req.rank = tmp[cru_pkg::RANK_W-1:0];
    end else if (roll < 90) begin
      // pick an ascending m-subset, then break one position now and then
      need = m;
      i = 0;
      for (j = 0; j < n; j++) begin
        if ($urandom_range(n - j - 1) < need) begin
          req.pos[i] = j[cru_pkg::POS_W-1:0];
          i++;
          need--;
        end
      end
      if (roll >= 80) req.pos[$urandom_range(m - 1)] = random_pos();
    end
    return req;
  endfunction

  function automatic request_t unrank_request(logic [cru_pkg::RANK_W-1:0] r);
    request_t req;
    req = '0;
    req.cmd = cru_pkg::CMD_UNRANK;
    req.rank = r;
    return req;
  endfunction

  function automatic request_t rank_request(
      logic [cru_pkg::POS_W-1:0] p0, logic [cru_pkg::POS_W-1:0] p1,
      logic [cru_pkg::POS_W-1:0] p2, logic [cru_pkg::POS_W-1:0] p3,
      logic [cru_pkg::POS_W-1:0] p4, logic [cru_pkg::POS_W-1:0] p5);
    request_t req;
    req = '0;
    req.cmd = cru_pkg::CMD_RANK;
    req.pos = {p5, p4, p3, p2, p1, p0};
    return req;
  endfunction

  task automatic send_request(request_t req);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= req.cmd;
    rank_in  <= req.rank;
    in_pos_0 <= req.pos[0];
    in_pos_1 <= req.pos[1];
    in_pos_2 <= req.pos[2];
    in_pos_3 <= req.pos[3];
    in_pos_4 <= req.pos[4];
    in_pos_5 <= req.pos[5];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_conversions.push_back(convert_item(req));
  endtask

  task automatic drain_conversions();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_conversions.size() != 0);
  endtask

  task automatic write_reg(logic [cru_pkg::CFG_IDX_W-1:0] idx, logic [cru_pkg::CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_size(logic [cru_pkg::CFG_W-1:0] n_data,
                              logic [cru_pkg::CFG_W-1:0] m_data);
    drain_conversions();
    write_reg(cru_pkg::REG_SET_SIZE, n_data);
    write_reg(cru_pkg::REG_SUBSET_SIZE, m_data);
    set_n = n_data[cru_pkg::SET_W-1:0];
    subset_m = m_data[cru_pkg::SUB_W-1:0];
  endtask

  task automatic program_random_size();
    int unsigned n;
    int unsigned m;
    if ($urandom_range(7) == 0) begin
      n = $urandom_range(127);
      m = $urandom_range(7);
    end else begin
      m = $urandom_range(1, cru_pkg::MAX_SUBSET);
      n = ($urandom_range(3) == 0) ? cru_pkg::MAX_SET : $urandom_range(m, cru_pkg::MAX_SET);
    end
    program_size(n[cru_pkg::CFG_W-1:0], m[cru_pkg::CFG_W-1:0]);
  endtask

  task automatic check_result();
    conversion_t                want;
    logic [cru_pkg::RANK_W-1:0] want_f [8];
    logic [cru_pkg::RANK_W-1:0] got_f [8];
    int                         k;
    if (pending_conversions.size() == 0) begin
      $display("%0t: result beat with nothing expected, rank_out %0d status %0d",
               $time, rank_out, status);
      fail_count++;
    end else begin
      want = pending_conversions.pop_front();
      want_f[0] = want.rank;
      for (k = 0; k < cru_pkg::MAX_SUBSET; k++) want_f[1 + k] = {21'd0, want.pos[k]};
      want_f[7] = {25'd0, want.status};
      got_f[0] = rank_out;
      got_f[1] = {21'd0, out_pos_0};
      got_f[2] = {21'd0, out_pos_1};
      got_f[3] = {21'd0, out_pos_2};
      got_f[4] = {21'd0, out_pos_3};
      got_f[5] = {21'd0, out_pos_4};
      got_f[6] = {21'd0, out_pos_5};
      got_f[7] = {25'd0, status};
      for (k = 0; k < 8; k++) begin
        if (got_f[k] !== want_f[k]) begin
          $display("%0t: %s expected %0d, got %0d", $time, field_name[k], want_f[k], got_f[k]);
          fail_count++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_result();
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  task automatic test_reset_defaults();
    send_request(unrank_request(27'd0));
    send_request(unrank_request(27'd27));
    send_request(unrank_request(27'd28));
    send_request(rank_request(6'd0, 6'd1, 6'd0, 6'd0, 6'd0, 6'd0));
    send_request(rank_request(6'd6, 6'd7, 6'd0, 6'd0, 6'd0, 6'd0));
    send_request(rank_request(6'd3, 6'd3, 6'd0, 6'd0, 6'd0, 6'd0));
    send_request(rank_request(6'd2, 6'd8, 6'd0, 6'd0, 6'd0, 6'd0));
  endtask

  task automatic test_extremes();
    program_size(7'd64, 7'd6);
    send_request(unrank_request(27'd0));
    send_request(unrank_request(27'd74974367));
    send_request(unrank_request(27'h7FFFFFF));
    send_request(rank_request(6'd58, 6'd59, 6'd60, 6'd61, 6'd62, 6'd63));
    program_size(7'd1, 7'd1);
    send_request(unrank_request(27'd0));
    send_request(unrank_request(27'd1));
    send_request(rank_request(6'd0, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63));
    send_request(rank_request(6'd1, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0));
    program_size(7'd6, 7'd6);
    send_request(unrank_request(27'd0));
    send_request(rank_request(6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5));
    send_request(rank_request(6'd0, 6'd1, 6'd2, 6'd3, 6'd5, 6'd4));
  endtask

  task automatic test_bad_config();
    program_size(7'd3, 7'd4);
    send_request(unrank_request(27'd0));
    program_size(7'd0, 7'd1);
    send_request(rank_request(6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0));
    program_size(7'd127, 7'd1);
    send_request(unrank_request(27'd0));
    program_size(7'd8, 7'd0);
    send_request(rank_request(6'd0, 6'd1, 6'd0, 6'd0, 6'd0, 6'd0));
    program_size(7'd8, 7'd7);
    send_request(unrank_request(27'd0));
    // upper data bits of the subset register drop, leaving m = 2
    program_size(7'd64, 7'h7A);
    send_request(unrank_request(27'd2015));
  endtask

  task automatic test_random_traffic(int tx_pct, int rx_pct, logic [cru_pkg::CFG_W-1:0] n0,
                                     logic [cru_pkg::CFG_W-1:0] m0);
    int s;
    drain_conversions();
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    program_size(n0, m0);
    for (s = 0; s < SETTINGS_PER_PHASE; s++) begin
      if (s != 0) program_random_size();
      repeat (ITEMS_PER_SETTING) send_request(random_request());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_extremes();
    test_bad_config();
    test_random_traffic(10, 58, 7'd64, 7'd6);
    test_random_traffic(58, 10, 7'd1, 7'd1);
    test_random_traffic(0, 0, 7'd64, 7'd1);
    drain_conversions();
    repeat (150) @(posedge clk);
    if (fail_count == 0) begin
      $display("[combination_rank_unrank_core] OK");
    end else begin
      $display("[combination_rank_unrank_core] ERROR");
    end
    $finish;
  end

endmodule
